### rtl/gated_pid_motor_power_top_defines.svh
// assertion macros for the gated pid motor power block
`ifndef GATED_PID_MOTOR_POWER_TOP_DEFINES_SVH
`define GATED_PID_MOTOR_POWER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define GPMP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GPMP_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define GPMP_ASSERT(lbl, clk, rst_n, prop, msg)
`define GPMP_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

### rtl/gpmp_pkg.sv
// shared types and constants of the gated pid motor power block
`timescale 1ns / 1ps
package gpmp_pkg;

    localparam int unsigned GAIN_W     = 32;
    localparam int unsigned PERIOD_W   = 16;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned REG_IDX_W  = 2;
    localparam int unsigned OP_W       = 2;
    localparam int unsigned POWER_W    = 8;
    localparam int unsigned SUM_W      = 48;
    localparam int unsigned DIGIT_W    = 16;
    localparam int unsigned MOP_W      = 48;
    localparam int unsigned N_DIGITS   = MOP_W / DIGIT_W;
    localparam int unsigned PROD_W     = GAIN_W + MOP_W;
    localparam int unsigned TERM_W     = 64;
    localparam int unsigned LIMIT_LOG2 = 60;
    localparam int unsigned FRAC_BITS  = 24;

    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_POS   = 2'd1;
    localparam logic [OP_W-1:0] OP_SPEED = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_PROP   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_DERIV  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_INTEG  = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_PERIOD = 2'd3;

    localparam logic [1:0] TERM_P = 2'd0;
    localparam logic [1:0] TERM_I = 2'd1;
    localparam logic [1:0] TERM_D = 2'd2;

    localparam logic [GAIN_W-1:0]   PROP_RST   = 32'd1174405;
    localparam logic [GAIN_W-1:0]   DERIV_RST  = 32'd33554432;
    localparam logic [GAIN_W-1:0]   INTEG_RST  = 32'd1678;
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd10;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    localparam logic signed [POWER_W-1:0] POWER_HI  = 8'sd127;
    localparam logic signed [POWER_W-1:0] POWER_LO  = -8'sd127;
    localparam logic signed [POWER_W-1:0] POWER_BAD = -8'sd128;

    typedef struct packed {
        logic       capture;
        logic       tick;
        logic       err;
        logic       eprod;
        logic       esat;
        logic       mul_load;
        logic [1:0] term_sel;
        logic       mul_step;
        logic       term_add;
        logic       div_load;
        logic       div_step;
        logic       div_add;
        logic       finish;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic            gate;
        logic [OP_W-1:0] op;
    } t_status;

endpackage

### rtl/gpmp_ctrl.sv
// sequencer of the pid update: item capture, term multiplies, divide, result
`timescale 1ns / 1ps
`include "gated_pid_motor_power_top_defines.svh"
module gpmp_ctrl #(
    parameter int unsigned SAMPLE_WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  gpmp_pkg::t_status i_status,
    output gpmp_pkg::t_cmd    o_cmd
);

    localparam int unsigned DIV_W = gpmp_pkg::GAIN_W + SAMPLE_WIDTH + 2;
    localparam int unsigned CNT_W = $clog2(DIV_W + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECIDE = 4'd1;
    localparam logic [3:0] S_ERR    = 4'd2;
    localparam logic [3:0] S_EPROD  = 4'd3;
    localparam logic [3:0] S_ESAT   = 4'd4;
    localparam logic [3:0] S_MLOAD  = 4'd5;
    localparam logic [3:0] S_MSTEP  = 4'd6;
    localparam logic [3:0] S_MADD   = 4'd7;
    localparam logic [3:0] S_DLOAD  = 4'd8;
    localparam logic [3:0] S_DSTEP  = 4'd9;
    localparam logic [3:0] S_DADD   = 4'd10;
    localparam logic [3:0] S_FINISH = 4'd11;
    localparam logic [3:0] S_DONE   = 4'd12;

    logic [3:0]       r_state;
    logic [3:0]       n_state;
    logic [1:0]       r_term;
    logic [1:0]       n_term;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             w_request;

    assign w_request = (i_status.op == gpmp_pkg::OP_POS) || (i_status.op == gpmp_pkg::OP_SPEED);

    always_comb begin
        n_state = r_state;
        n_term  = r_term;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (w_request && i_status.gate) begin
                    n_state = S_ERR;
                end else begin
                    o_cmd.tick = (i_status.op == gpmp_pkg::OP_TICK);
                    n_state    = S_DONE;
                end
            end
            S_ERR: begin
                o_cmd.err = 1'b1;
                n_term    = gpmp_pkg::TERM_P;
                n_state   = S_EPROD;
            end
            S_EPROD: begin
                o_cmd.eprod = 1'b1;
                n_state     = S_ESAT;
            end
            S_ESAT: begin
                o_cmd.esat = 1'b1;
                n_state    = S_MLOAD;
            end
            S_MLOAD: begin
                o_cmd.mul_load = 1'b1;
                o_cmd.term_sel = r_term;
                n_cnt          = '0;
                n_state        = S_MSTEP;
            end
            S_MSTEP: begin
                o_cmd.mul_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(gpmp_pkg::N_DIGITS - 1)) begin
                    n_state = (r_term == gpmp_pkg::TERM_D) ? S_DLOAD : S_MADD;
                end
            end
            S_MADD: begin
                o_cmd.term_add = 1'b1;
                n_term  = (r_term == gpmp_pkg::TERM_P) ? gpmp_pkg::TERM_I : gpmp_pkg::TERM_D;
                n_state = S_MLOAD;
            end
            S_DLOAD: begin
                o_cmd.div_load = 1'b1;
                n_cnt          = '0;
                n_state        = S_DSTEP;
            end
            S_DSTEP: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    n_state = S_DADD;
                end
            end
            S_DADD: begin
                o_cmd.div_add = 1'b1;
                n_state       = S_FINISH;
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        priority if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_term      <= gpmp_pkg::TERM_P;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_term      <= n_term;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    `GPMP_ASSERT(a_div_count, i_clk, i_rst_n, (r_state == S_DSTEP) |-> (r_cnt < CNT_W'(DIV_W)), "divide step count overrun")
    `GPMP_ASSERT(a_one_op, i_clk, i_rst_n, $onehot0({o_cmd.capture, o_cmd.tick, o_cmd.err, o_cmd.eprod, o_cmd.esat, o_cmd.mul_load, o_cmd.mul_step, o_cmd.term_add, o_cmd.div_load, o_cmd.div_step, o_cmd.div_add, o_cmd.finish, o_cmd.out_load}), "more than one datapath operation")
    `GPMP_ASSERT_NEXT(a_accept_decide, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_state == S_DECIDE, "accepted request not evaluated")

endmodule

### rtl/gpmp_dp.sv
// pid datapath: registers, state, shared digit multiplier and radix-2 divider
`timescale 1ns / 1ps
`include "gated_pid_motor_power_top_defines.svh"
module gpmp_dp #(
    parameter int unsigned SAMPLE_WIDTH = 16,
    parameter int unsigned TIMER_WIDTH  = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [gpmp_pkg::REG_IDX_W-1:0]        i_cfg_index,
    input  logic [gpmp_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic [gpmp_pkg::OP_W-1:0]             i_operation,
    input  logic signed [SAMPLE_WIDTH-1:0]        i_measured,
    input  logic signed [SAMPLE_WIDTH-1:0]        i_setpoint,
    input  gpmp_pkg::t_cmd                        i_cmd,
    output gpmp_pkg::t_status                     o_status,
    output logic signed [gpmp_pkg::POWER_W-1:0]   o_drive,
    output logic                                  o_updated
);

    localparam int unsigned GAIN_W   = gpmp_pkg::GAIN_W;
    localparam int unsigned PERIOD_W = gpmp_pkg::PERIOD_W;
    localparam int unsigned SUM_W    = gpmp_pkg::SUM_W;
    localparam int unsigned MOP_W    = gpmp_pkg::MOP_W;
    localparam int unsigned DIGIT_W  = gpmp_pkg::DIGIT_W;
    localparam int unsigned PROD_W   = gpmp_pkg::PROD_W;
    localparam int unsigned TERM_W   = gpmp_pkg::TERM_W;
    localparam int unsigned POWER_W  = gpmp_pkg::POWER_W;
    localparam int unsigned PMAG_W   = POWER_W - 1;
    localparam int unsigned SSUM_W   = POWER_W + 1;
    localparam int unsigned ERR_W    = SAMPLE_WIDTH + 1;
    localparam int unsigned DE_W     = SAMPLE_WIDTH + 2;
    localparam int unsigned EPROD_W  = ERR_W + PERIOD_W + 1;
    localparam int unsigned ACC_W    = ((EPROD_W > SUM_W) ? EPROD_W : SUM_W) + 1;
    localparam int unsigned DIV_W    = GAIN_W + DE_W;
    localparam int unsigned LIMIT_W  = gpmp_pkg::LIMIT_LOG2 + 1;
    localparam int unsigned QCMP_W   = (DIV_W > LIMIT_W) ? DIV_W : LIMIT_W;
    localparam int unsigned CMP_W    = (TIMER_WIDTH > PERIOD_W) ? TIMER_WIDTH : PERIOD_W;

    localparam logic [PROD_W-1:0] LIMIT_P = PROD_W'(1) << gpmp_pkg::LIMIT_LOG2;
    localparam logic [QCMP_W-1:0] LIMIT_Q = QCMP_W'(1) << gpmp_pkg::LIMIT_LOG2;

    logic [GAIN_W-1:0]                r_prop_gain;
    logic [GAIN_W-1:0]                r_deriv_gain;
    logic [GAIN_W-1:0]                r_integ_gain;
    logic [PERIOD_W-1:0]              r_period;
    logic [TIMER_WIDTH-1:0]           r_elapsed;
    logic signed [ERR_W-1:0]          r_last_err;
    logic signed [SUM_W-1:0]          r_err_sum;
    logic signed [POWER_W-1:0]        r_held;
    logic signed [POWER_W-1:0]        r_summed;

    logic [gpmp_pkg::OP_W-1:0]        r_op;
    logic signed [SAMPLE_WIDTH-1:0]   r_meas;
    logic signed [SAMPLE_WIDTH-1:0]   r_setp;
    logic signed [ERR_W-1:0]          r_err;
    logic signed [DE_W-1:0]           r_de;
    logic signed [EPROD_W-1:0]        r_eprod;
    logic [1:0]                       r_sel;
    logic [MOP_W-1:0]                 r_mop;
    logic                             r_mneg;
    logic [PROD_W-1:0]                r_acc;
    logic signed [TERM_W-1:0]         r_total;
    logic [DIV_W-1:0]                 r_dividend;
    logic [PERIOD_W-1:0]              r_rem;
    logic                             r_upd;
    logic signed [POWER_W-1:0]        r_drive;
    logic                             r_updated;

    logic signed [ERR_W-1:0]          w_err;
    logic signed [ACC_W-1:0]          w_sum;
    logic                             w_ovf_pos;
    logic                             w_ovf_neg;
    logic signed [SUM_W-1:0]          w_sum_sat;
    logic [ERR_W-1:0]                 w_err_mag;
    logic [SUM_W-1:0]                 w_esum_mag;
    logic [DE_W-1:0]                  w_de_mag;
    logic [MOP_W-1:0]                 w_mop_init;
    logic                             w_mneg_init;
    logic [GAIN_W-1:0]                w_gain;
    logic [GAIN_W+DIGIT_W-1:0]        w_pp;
    logic [PROD_W-1:0]                w_acc_clamp;
    logic signed [TERM_W-1:0]         w_term;
    logic [PERIOD_W:0]                w_trial;
    logic [PERIOD_W:0]                w_diff;
    logic                             w_ge;
    logic [QCMP_W-1:0]                w_quo;
    logic [QCMP_W-1:0]                w_quo_clamp;
    logic signed [TERM_W-1:0]         w_dterm;
    logic [TERM_W-1:0]                w_tot_mag;
    logic [TERM_W-1:0]                w_shift;
    logic [PMAG_W-1:0]                w_pmag;
    logic signed [POWER_W-1:0]        w_power;
    logic signed [SSUM_W-1:0]         w_ssum;
    logic signed [POWER_W-1:0]        w_ssum_sat;

    assign w_err = ERR_W'(r_setp) - ERR_W'(r_meas);

    assign w_sum     = ACC_W'(r_err_sum) + ACC_W'(r_eprod);
    assign w_ovf_pos = !w_sum[ACC_W-1] && (|w_sum[ACC_W-2:SUM_W-1]);
    assign w_ovf_neg = w_sum[ACC_W-1] && !(&w_sum[ACC_W-2:SUM_W-1]);
    assign w_sum_sat = w_ovf_pos ? gpmp_pkg::SUM_MAX :
                       (w_ovf_neg ? gpmp_pkg::SUM_MIN : w_sum[SUM_W-1:0]);

    assign w_err_mag  = r_err[ERR_W-1] ? $unsigned(-r_err) : $unsigned(r_err);
    assign w_esum_mag = r_err_sum[SUM_W-1] ? $unsigned(-r_err_sum) : $unsigned(r_err_sum);
    assign w_de_mag   = r_de[DE_W-1] ? $unsigned(-r_de) : $unsigned(r_de);

    always_comb begin
        unique case (i_cmd.term_sel)
            gpmp_pkg::TERM_P: begin
                w_mop_init  = MOP_W'(w_err_mag);
                w_mneg_init = r_err[ERR_W-1];
            end
            gpmp_pkg::TERM_I: begin
                w_mop_init  = MOP_W'(w_esum_mag);
                w_mneg_init = r_err_sum[SUM_W-1];
            end
            default: begin
                w_mop_init  = MOP_W'(w_de_mag);
                w_mneg_init = r_de[DE_W-1];
            end
        endcase
    end

    always_comb begin
        unique case (r_sel)
            gpmp_pkg::TERM_P: w_gain = r_prop_gain;
            gpmp_pkg::TERM_I: w_gain = r_integ_gain;
            default:          w_gain = r_deriv_gain;
        endcase
    end

    assign w_pp        = w_gain * r_mop[MOP_W-1 -: DIGIT_W];
    assign w_acc_clamp = (r_acc > LIMIT_P) ? LIMIT_P : r_acc;
    assign w_term      = signed'(TERM_W'(w_acc_clamp));

    assign w_trial = {r_rem, r_dividend[DIV_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_period});
    assign w_diff  = w_trial - {1'b0, r_period};

    assign w_quo       = QCMP_W'(r_dividend);
    assign w_quo_clamp = (w_quo > LIMIT_Q) ? LIMIT_Q : w_quo;
    assign w_dterm     = signed'(TERM_W'(w_quo_clamp));

    assign w_tot_mag = r_total[TERM_W-1] ? $unsigned(-r_total) : $unsigned(r_total);
    assign w_shift   = w_tot_mag >> gpmp_pkg::FRAC_BITS;
    assign w_pmag    = (w_shift > TERM_W'({PMAG_W{1'b1}})) ? {PMAG_W{1'b1}} : w_shift[PMAG_W-1:0];
    assign w_power   = r_total[TERM_W-1] ? -signed'({1'b0, w_pmag}) : signed'({1'b0, w_pmag});

    assign w_ssum     = SSUM_W'(r_summed) + SSUM_W'(w_power);
    assign w_ssum_sat = (w_ssum > SSUM_W'(gpmp_pkg::POWER_HI)) ? gpmp_pkg::POWER_HI :
                        ((w_ssum < SSUM_W'(gpmp_pkg::POWER_LO)) ? gpmp_pkg::POWER_LO :
                         w_ssum[POWER_W-1:0]);

    // configuration and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain  <= gpmp_pkg::PROP_RST;
            r_deriv_gain <= gpmp_pkg::DERIV_RST;
            r_integ_gain <= gpmp_pkg::INTEG_RST;
            r_period     <= gpmp_pkg::PERIOD_RST;
            r_elapsed    <= '0;
            r_last_err   <= '0;
            r_err_sum    <= '0;
            r_held       <= '0;
            r_summed     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    gpmp_pkg::REG_PROP: begin
                        if (i_cfg_data != '0) r_prop_gain <= i_cfg_data;
                    end
                    gpmp_pkg::REG_DERIV: begin
                        if (i_cfg_data != '0) r_deriv_gain <= i_cfg_data;
                    end
                    gpmp_pkg::REG_INTEG: begin
                        if (i_cfg_data != '0) r_integ_gain <= i_cfg_data;
                    end
                    default: begin
                        if (i_cfg_data[PERIOD_W-1:0] != '0) r_period <= i_cfg_data[PERIOD_W-1:0];
                    end
                endcase
            end
            if (i_cmd.tick && (r_elapsed != '1)) begin
                r_elapsed <= r_elapsed + 1'b1;
            end
            if (i_cmd.esat) begin
                r_err_sum  <= w_sum_sat;
                r_last_err <= r_err;
            end
            if (i_cmd.finish) begin
                r_held    <= w_power;
                r_elapsed <= '0;
                if (r_op == gpmp_pkg::OP_SPEED) begin
                    r_summed <= w_ssum_sat;
                end
            end
        end
    end

    // working registers of one request
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_operation;
            r_meas <= i_measured;
            r_setp <= i_setpoint;
            r_upd  <= 1'b0;
        end
        if (i_cmd.err) begin
            r_err <= w_err;
        end
        if (i_cmd.eprod) begin
            r_de    <= DE_W'(r_err) - DE_W'(r_last_err);
            r_eprod <= EPROD_W'(r_err) * EPROD_W'(signed'({1'b0, r_period}));
        end
        if (i_cmd.esat) begin
            r_total <= '0;
        end
        if (i_cmd.mul_load) begin
            r_sel  <= i_cmd.term_sel;
            r_mop  <= w_mop_init;
            r_mneg <= w_mneg_init;
            r_acc  <= '0;
        end
        if (i_cmd.mul_step) begin
            r_acc <= (r_acc << DIGIT_W) + PROD_W'(w_pp);
            r_mop <= r_mop << DIGIT_W;
        end
        if (i_cmd.term_add) begin
            r_total <= r_mneg ? (r_total - w_term) : (r_total + w_term);
        end
        if (i_cmd.div_load) begin
            r_dividend <= r_acc[DIV_W-1:0];
            r_rem      <= '0;
        end
        if (i_cmd.div_step) begin
            r_dividend <= {r_dividend[DIV_W-2:0], w_ge};
            r_rem      <= w_ge ? w_diff[PERIOD_W-1:0] : w_trial[PERIOD_W-1:0];
        end
        if (i_cmd.div_add) begin
            r_total <= r_mneg ? (r_total - w_dterm) : (r_total + w_dterm);
        end
        if (i_cmd.finish) begin
            r_upd <= 1'b1;
        end
        if (i_cmd.out_load) begin
            r_drive   <= (r_op == gpmp_pkg::OP_SPEED) ? r_summed : r_held;
            r_updated <= r_upd;
        end
    end

    assign o_status.gate = (CMP_W'(r_elapsed) > CMP_W'(r_period));
    assign o_status.op   = r_op;
    assign o_drive       = r_drive;
    assign o_updated     = r_updated;

    `GPMP_ASSERT(a_power_range, i_clk, i_rst_n, (r_held != gpmp_pkg::POWER_BAD) && (r_summed != gpmp_pkg::POWER_BAD), "power left the symmetric range")

endmodule

### rtl/gated_pid_motor_power_top.sv
// top level of the timer gated pid motor power controller
//
//  channel  direction  handshake                   payload
//  in       request    i_in_valid / o_in_stall     i_operation, i_measured, i_setpoint
//  out      result     o_out_valid / i_out_stall   o_drive, o_updated
//  cfg      write      i_cfg_wr_en                 i_cfg_index, i_cfg_data
//
//  a tick or a request that does not open the gate: capture, the gate decision, then the result
//  an update runs the 3 x 3 digit passes of the shared 32 x 16 multiplier and
//  the one bit per cycle divide by the period
//  one request at a time; the next is taken while a finished result waits to be taken
//  a stalled result holds the sequencer in its last step until the output register frees
//  reset (synchronous, active low) restores gains, period and all controller state
`timescale 1ns / 1ps
module gated_pid_motor_power_top #(
    parameter int unsigned SAMPLE_WIDTH = 16,
    parameter int unsigned TIMER_WIDTH  = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [gpmp_pkg::REG_IDX_W-1:0]        i_cfg_index,
    input  logic [gpmp_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [gpmp_pkg::OP_W-1:0]             i_operation,
    input  logic signed [SAMPLE_WIDTH-1:0]        i_measured,
    input  logic signed [SAMPLE_WIDTH-1:0]        i_setpoint,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [gpmp_pkg::POWER_W-1:0]   o_drive,
    output logic                                  o_updated
);

    gpmp_pkg::t_cmd    w_cmd;
    gpmp_pkg::t_status w_status;

    gpmp_ctrl #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    gpmp_dp #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .TIMER_WIDTH  (TIMER_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_operation (i_operation),
        .i_measured  (i_measured),
        .i_setpoint  (i_setpoint),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_drive     (o_drive),
        .o_updated   (o_updated)
    );

endmodule
